### hw/rtl/mmss_pkg.sv
// Shared types and constants for the MM:SS up/down BCD timer.
`timescale 1ns / 1ps

package mmss_pkg;

    typedef logic [3:0] t_digit;
    typedef logic [1:0] t_mode;
    typedef logic [2:0] t_kind;
    typedef logic [15:0] t_ticks;

    // Request kinds.
    localparam t_kind KIND_TICK  = 3'd0;
    localparam t_kind KIND_UP    = 3'd1;
    localparam t_kind KIND_DOWN  = 3'd2;
    localparam t_kind KIND_STOP  = 3'd3;
    localparam t_kind KIND_CLEAR = 3'd4;
    localparam t_kind KIND_LOAD  = 3'd5;

    // Run modes.
    localparam t_mode MODE_STOP = 2'd0;
    localparam t_mode MODE_UP   = 2'd1;
    localparam t_mode MODE_DOWN = 2'd2;

    // Digit limits for counting up, and the values loaded on a borrow.
    localparam t_digit ONES_LIMIT = 4'd10;
    localparam t_digit TENS_LIMIT = 4'd6;
    localparam t_digit ONES_MAX   = 4'd9;
    localparam t_digit TENS_MAX   = 4'd5;

    localparam t_ticks TICKS_RESET = 16'd7812;

    typedef struct packed {
        t_kind  kind;
        t_digit load_min_tens;
        t_digit load_min_ones;
        t_digit load_sec_tens;
        t_digit load_sec_ones;
    } t_req;

    typedef struct packed {
        t_digit min_tens;
        t_digit min_ones;
        t_digit sec_tens;
        t_digit sec_ones;
        t_mode  run_mode;
        logic   stepped;
    } t_rsp;

endpackage

### hw/rtl/mmss_stream_if.sv
// Valid/ready channel interface carrying one payload per request.
`timescale 1ns / 1ps

interface mmss_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/mmss_up_down_bcd_timer_core.sv
// Top level of the MM:SS up/down BCD timer with prescaler and command decode.
`timescale 1ns / 1ps
// Results are registered: the result of an accepted request is held in the output register.
// Throughput: one request per cycle; the only limit is the single output register,
// which takes a new result whenever it is empty or being drained in the same cycle.
// Reset (i_rst_n low, synchronous): digits 00:00, stopped, prescaler at zero,
// ticks_per_step back to 7812, and the output register empty.

module mmss_up_down_bcd_timer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mmss_stream_if.sink         i_req,
    mmss_stream_if.source       o_rsp,
    mmss_stream_if.sink         i_cfg
);

    // Timer state. The digits are held minute tens first.
    mmss_pkg::t_digit r_mt, r_mo, r_st, r_so;
    mmss_pkg::t_digit n_mt, n_mo, n_st, n_so;
    mmss_pkg::t_mode  r_mode, n_mode;
    mmss_pkg::t_ticks r_count, n_count;
    mmss_pkg::t_ticks r_ticks;

    // Output register.
    logic           r_out_valid;
    mmss_pkg::t_rsp r_rsp;
    mmss_pkg::t_rsp n_rsp;

    logic req_fire;

    // Step logic.
    logic             running;
    logic             tick_run;
    logic             limit_hit;
    logic             n_stepped;
    mmss_pkg::t_ticks count_inc;
    mmss_pkg::t_digit up_mt, up_mo, up_st, up_so;
    mmss_pkg::t_digit inc_mt, inc_mo, inc_st, inc_so;
    mmss_pkg::t_digit dn_mt, dn_mo, dn_st, dn_so;
    logic             dn_moved;

    // The request side is free whenever the output register can take a new result.
    assign i_req.ready = ~r_out_valid | o_rsp.ready;
    assign req_fire    = i_req.valid & i_req.ready;

    // The configuration register can be written at any time.
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // Prescaler: the count advances only on a tick while running, wraps at 16 bits,
    // and is compared for equality, so a limit below the count is met after the wrap.
    assign running   = (r_mode == mmss_pkg::MODE_UP) || (r_mode == mmss_pkg::MODE_DOWN);
    assign tick_run  = (i_req.payload.kind == mmss_pkg::KIND_TICK) && running;
    assign count_inc = r_count + 16'd1;
    assign limit_hit = (count_inc == r_ticks);

    // Counting up: each digit that reaches or passes its limit returns to zero and
    // carries into the next one. A loaded 15 wraps to zero without a carry.
    always_comb begin
        inc_so = r_so + 4'd1;
        inc_st = r_st + 4'd1;
        inc_mo = r_mo + 4'd1;
        inc_mt = r_mt + 4'd1;
        up_mt  = r_mt;
        up_mo  = r_mo;
        up_st  = r_st;
        up_so  = inc_so;
        if (inc_so >= mmss_pkg::ONES_LIMIT) begin
            up_so = '0;
            up_st = inc_st;
            if (inc_st >= mmss_pkg::TENS_LIMIT) begin
                up_st = '0;
                up_mo = inc_mo;
                if (inc_mo >= mmss_pkg::ONES_LIMIT) begin
                    up_mo = '0;
                    up_mt = (inc_mt >= mmss_pkg::TENS_LIMIT) ? '0 : inc_mt;
                end
            end
        end
    end

    // Counting down: borrow from the lowest nonzero digit; at 00:00 the time holds.
    always_comb begin
        dn_mt    = r_mt;
        dn_mo    = r_mo;
        dn_st    = r_st;
        dn_so    = r_so;
        dn_moved = 1'b1;
        priority if (r_so != '0) begin
            dn_so = r_so - 4'd1;
        end else if (r_st != '0) begin
            dn_st = r_st - 4'd1;
            dn_so = mmss_pkg::ONES_MAX;
        end else if (r_mo != '0) begin
            dn_mo = r_mo - 4'd1;
            dn_st = mmss_pkg::TENS_MAX;
            dn_so = mmss_pkg::ONES_MAX;
        end else if (r_mt != '0) begin
            dn_mt = r_mt - 4'd1;
            dn_mo = mmss_pkg::ONES_MAX;
            dn_st = mmss_pkg::TENS_MAX;
            dn_so = mmss_pkg::ONES_MAX;
        end else begin
            dn_moved = 1'b0;
        end
    end

    // Request decode. Stop, clear, load and mode changes keep the prescaler count.
    always_comb begin
        n_mt      = r_mt;
        n_mo      = r_mo;
        n_st      = r_st;
        n_so      = r_so;
        n_mode    = r_mode;
        n_count   = r_count;
        n_stepped = 1'b0;
        unique case (i_req.payload.kind)
            mmss_pkg::KIND_TICK: begin
                if (tick_run) begin
                    n_count = limit_hit ? '0 : count_inc;
                    if (limit_hit) begin
                        if (r_mode == mmss_pkg::MODE_UP) begin
                            {n_mt, n_mo, n_st, n_so} = {up_mt, up_mo, up_st, up_so};
                            n_stepped = 1'b1;
                        end else begin
                            {n_mt, n_mo, n_st, n_so} = {dn_mt, dn_mo, dn_st, dn_so};
                            n_stepped = dn_moved;
                        end
                    end
                end
            end
            mmss_pkg::KIND_UP:    n_mode = mmss_pkg::MODE_UP;
            mmss_pkg::KIND_DOWN:  n_mode = mmss_pkg::MODE_DOWN;
            mmss_pkg::KIND_STOP:  n_mode = mmss_pkg::MODE_STOP;
            mmss_pkg::KIND_CLEAR: begin
                {n_mt, n_mo, n_st, n_so} = '0;
            end
            mmss_pkg::KIND_LOAD: begin
                n_mt = i_req.payload.load_min_tens;
                n_mo = i_req.payload.load_min_ones;
                n_st = i_req.payload.load_sec_tens;
                n_so = i_req.payload.load_sec_ones;
            end
            default: begin
                // Unused kinds leave the state alone and still report it.
            end
        endcase

        n_rsp.min_tens = n_mt;
        n_rsp.min_ones = n_mo;
        n_rsp.sec_tens = n_st;
        n_rsp.sec_ones = n_so;
        n_rsp.run_mode = n_mode;
        n_rsp.stepped  = n_stepped;
    end

    // Control state and timer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mt        <= '0;
            r_mo        <= '0;
            r_st        <= '0;
            r_so        <= '0;
            r_mode      <= mmss_pkg::MODE_STOP;
            r_count     <= '0;
            r_ticks     <= mmss_pkg::TICKS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (req_fire) begin
                r_mt    <= n_mt;
                r_mo    <= n_mo;
                r_st    <= n_st;
                r_so    <= n_so;
                r_mode  <= n_mode;
                r_count <= n_count;
            end
            if (i_cfg.valid) begin
                r_ticks <= i_cfg.payload;
            end
            if (req_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rsp <= n_rsp;
        end
    end

`ifndef SYNTHESIS
    // A result that steps the time can only come from a running timer.
    a_step_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.stepped) |-> (o_rsp.payload.run_mode != mmss_pkg::MODE_STOP))
        else $error("stepped result reported while stopped");

    // A stalled result must hold off new requests.
    a_stall_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request accepted while result is stalled");

    // A stop request is reported as stopped in the very next result.
    a_stop_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.payload.kind == mmss_pkg::KIND_STOP)
        |=> (o_rsp.valid && o_rsp.payload.run_mode == mmss_pkg::MODE_STOP))
        else $error("stop request not reflected in result");

    // The prescaler only moves while the timer is running.
    a_count_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == mmss_pkg::MODE_STOP) |=> $stable(r_count))
        else $error("prescaler moved while stopped");
`endif

endmodule
